/* design/tccs_pkg.sv */
// Shared types, constants and helper functions of the text console cursor and scroll core.
package tccs_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CODE_BS = 8'd8;
    localparam logic [7:0] CODE_CR = 8'd13;
    localparam logic [7:0] CODE_LF = 8'd10;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        KIND_CELL       = 3'd0,
        KIND_SCROLL     = 3'd1,
        KIND_CURSOR     = 3'd2,
        KIND_FONT_ERROR = 3'd3,
        KIND_CLEARED    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        CFG_COLUMNS = 3'd0,
        CFG_ROWS    = 3'd1,
        CFG_LOWEST  = 3'd2,
        CFG_HIGHEST = 3'd3,
        CFG_COLOUR  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] char_code;
        logic       end_of_write;
    } in_word_t;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  ring_row;
        logic [5:0]  screen_row;
        logic [6:0]  column;
        logic [7:0]  glyph_index;
        logic [15:0] cell_colour;
        logic [5:0]  top_row;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  columns_in_use;
        logic [6:0]  rows_in_use;
        logic [7:0]  lowest_code;
        logic [7:0]  highest_code;
        logic [15:0] text_colour;
    } cfg_t;

    // Up to three results of one character, already packed towards slot 0.
    typedef struct packed {
        logic [1:0]      count;
        out_word_t [2:0] word;
    } push_t;

    function automatic logic [5:0] row_next(input logic [5:0] v, input logic [6:0] period);
        logic [6:0] s;
        begin
            s = {1'b0, v} + 7'd1;
            return (s >= period) ? 6'd0 : s[5:0];
        end
    endfunction

    function automatic logic [5:0] row_prev(input logic [5:0] v, input logic [6:0] period);
        logic [6:0] p;
        begin
            p = period - 7'd1;
            return (v == 6'd0) ? p[5:0] : v - 6'd1;
        end
    endfunction

    function automatic logic [6:0] col_next(input logic [6:0] v, input logic [7:0] period);
        logic [7:0] s;
        begin
            s = {1'b0, v} + 8'd1;
            return (s >= period) ? 7'd0 : s[6:0];
        end
    endfunction

    function automatic logic [6:0] col_prev(input logic [6:0] v, input logic [7:0] period);
        logic [7:0] p;
        begin
            p = period - 8'd1;
            return (v == 7'd0) ? p[6:0] : v - 7'd1;
        end
    endfunction

    function automatic logic [5:0] screen_of(input logic [5:0] ring, input logic [5:0] start,
                                             input logic [6:0] period);
        logic [6:0] d;
        begin
            if (ring >= start)
                d = {1'b0, ring} - {1'b0, start};
            else
                d = {1'b0, ring} + period - {1'b0, start};
            return d[5:0];
        end
    endfunction

endpackage

/* design/tccs_cfg.sv */
// Configuration register bank of the text console cursor and scroll core.
module tccs_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output tccs_pkg::cfg_t     cfg
);

    tccs_pkg::cfg_t cfg_reg;
    tccs_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                tccs_pkg::CFG_COLUMNS: cfg_next.columns_in_use = cfg_data[7:0];
                tccs_pkg::CFG_ROWS:    cfg_next.rows_in_use    = cfg_data[6:0];
                tccs_pkg::CFG_LOWEST:  cfg_next.lowest_code    = cfg_data[7:0];
                tccs_pkg::CFG_HIGHEST: cfg_next.highest_code   = cfg_data[7:0];
                tccs_pkg::CFG_COLOUR:  cfg_next.text_colour    = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.columns_in_use <= 8'd80;
            cfg_reg.rows_in_use    <= 7'd30;
            cfg_reg.lowest_code    <= 8'd32;
            cfg_reg.highest_code   <= 8'd126;
            cfg_reg.text_colour    <= 16'hFFFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/tccs_step.sv */
// Input register, cursor and scroll state, and per-character result generation.
module tccs_step (
    input  logic               clk,
    input  logic               rst_n,
    input  tccs_pkg::cfg_t     cfg,
    input  logic               char_valid,
    output logic               char_stall,
    input  tccs_pkg::in_word_t char_word,
    input  logic               space_ok,
    output logic               push_en,
    output tccs_pkg::push_t    push
);

    logic               in_valid_reg, in_valid_next;
    tccs_pkg::in_word_t in_word_reg;
    logic [5:0]         cursor_row_reg, cursor_row_next;
    logic [6:0]         cursor_column_reg, cursor_column_next;
    logic [5:0]         start_row_reg, start_row_next;
    logic               discarding_reg, discarding_next;

    logic       fire;
    logic       accept;
    logic [7:0] cols;
    logic [6:0] rows;
    logic [5:0] cr;
    logic [6:0] cc;
    logic [5:0] sr;
    logic       v0, v1, v2;
    tccs_pkg::out_word_t c0, c1, c2;
    tccs_pkg::out_word_t s0, s1, s2;
    logic [1:0] n;

    assign fire       = in_valid_reg && space_ok;
    assign char_stall = in_valid_reg && !space_ok;
    assign accept     = char_valid && !char_stall;
    assign push_en    = fire;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    // A zero or oversize geometry is clamped to the supported range.
    always_comb
    begin
        if (cfg.columns_in_use == 8'd0)
            cols = 8'd1;
        else if (cfg.columns_in_use > 8'(tccs_pkg::MAX_COLUMNS))
            cols = 8'(tccs_pkg::MAX_COLUMNS);
        else
            cols = cfg.columns_in_use;

        if (cfg.rows_in_use == 7'd0)
            rows = 7'd1;
        else if (cfg.rows_in_use > 7'(tccs_pkg::MAX_ROWS))
            rows = 7'(tccs_pkg::MAX_ROWS);
        else
            rows = cfg.rows_in_use;
    end

    // State that lies outside a shrunk geometry is taken as zero.
    assign cr = ({1'b0, cursor_row_reg} >= rows) ? 6'd0 : cursor_row_reg;
    assign cc = ({1'b0, cursor_column_reg} >= cols) ? 7'd0 : cursor_column_reg;
    assign sr = ({1'b0, start_row_reg} >= rows) ? 6'd0 : start_row_reg;

    always_comb
    begin
        cursor_row_next    = cr;
        cursor_column_next = cc;
        start_row_next     = sr;
        discarding_next    = discarding_reg;
        v0 = 1'b0;
        v1 = 1'b0;
        v2 = 1'b0;

        c0.kind        = tccs_pkg::KIND_CELL;
        c0.ring_row    = cr;
        c0.screen_row  = tccs_pkg::screen_of(cr, sr, rows);
        c0.column      = cc;
        c0.glyph_index = in_word_reg.char_code - cfg.lowest_code;
        c0.cell_colour = cfg.text_colour;
        c0.top_row     = sr;
        c0.last        = 1'b0;

        if (in_word_reg.opcode == tccs_pkg::OP_CLEAR)
        begin
            cursor_row_next    = 6'd0;
            cursor_column_next = 7'd0;
            start_row_next     = 6'd0;
            discarding_next    = 1'b0;
            v0                 = 1'b1;
            c0                 = '0;
            c0.kind            = tccs_pkg::KIND_CLEARED;
        end
        else if (discarding_reg)
        begin
            if (in_word_reg.end_of_write)
                discarding_next = 1'b0;
        end
        else if (in_word_reg.char_code == tccs_pkg::CODE_BS)
        begin
            if (!(cc == 7'd0 && cr == sr))
            begin
                if (cc == 7'd0)
                    cursor_row_next = tccs_pkg::row_prev(cr, rows);
                cursor_column_next = tccs_pkg::col_prev(cc, cols);
            end
            v2 = in_word_reg.end_of_write;
        end
        else if (in_word_reg.char_code == tccs_pkg::CODE_CR)
        begin
            cursor_column_next = 7'd0;
            v2 = in_word_reg.end_of_write;
        end
        else if (in_word_reg.char_code == tccs_pkg::CODE_LF)
        begin
            cursor_row_next = tccs_pkg::row_next(cr, rows);
            if (cursor_row_next == sr)
            begin
                start_row_next = tccs_pkg::row_next(sr, rows);
                v1 = 1'b1;
            end
            v2 = in_word_reg.end_of_write;
        end
        else if (in_word_reg.char_code < cfg.lowest_code ||
                 in_word_reg.char_code > cfg.highest_code)
        begin
            v0              = 1'b1;
            c0.kind         = tccs_pkg::KIND_FONT_ERROR;
            c0.glyph_index  = 8'd0;
            c0.cell_colour  = 16'd0;
            discarding_next = !in_word_reg.end_of_write;
        end
        else
        begin
            v0 = 1'b1;
            cursor_column_next = tccs_pkg::col_next(cc, cols);
            if (cursor_column_next == 7'd0)
            begin
                cursor_row_next = tccs_pkg::row_next(cr, rows);
                if (cursor_row_next == sr)
                begin
                    start_row_next = tccs_pkg::row_next(sr, rows);
                    v1 = 1'b1;
                end
            end
            v2 = in_word_reg.end_of_write;
        end
    end

    always_comb
    begin
        c1.kind        = tccs_pkg::KIND_SCROLL;
        c1.ring_row    = cursor_row_next;
        c1.screen_row  = tccs_pkg::screen_of(cursor_row_next, start_row_next, rows);
        c1.column      = cursor_column_next;
        c1.glyph_index = 8'd0;
        c1.cell_colour = 16'd0;
        c1.top_row     = start_row_next;
        c1.last        = 1'b0;

        c2      = c1;
        c2.kind = tccs_pkg::KIND_CURSOR;
    end

    // Pack the present results towards slot 0 and flag the final one.
    always_comb
    begin
        n  = 2'({1'b0, v0} + {1'b0, v1} + {1'b0, v2});
        s0 = v0 ? c0 : (v1 ? c1 : c2);
        s1 = (v0 && v1) ? c1 : c2;
        s2 = c2;
        s0.last = (n == 2'd1);
        s1.last = (n == 2'd2);
        s2.last = (n == 2'd3);
        push.count   = n;
        push.word[0] = s0;
        push.word[1] = s1;
        push.word[2] = s2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            cursor_row_reg    <= 6'd0;
            cursor_column_reg <= 7'd0;
            start_row_reg     <= 6'd0;
            discarding_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (fire)
            begin
                cursor_row_reg    <= cursor_row_next;
                cursor_column_reg <= cursor_column_next;
                start_row_reg     <= start_row_next;
                discarding_reg    <= discarding_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_word_reg <= char_word;
    end

endmodule

/* design/tccs_fifo.sv */
// Result queue that takes up to three words a cycle and hands out one while not stalled.
module tccs_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_en,
    input  tccs_pkg::push_t     push,
    output logic                space_ok,
    output logic                res_valid,
    input  logic                res_stall,
    output tccs_pkg::out_word_t res_word
);

    localparam int CW = $clog2(tccs_pkg::QUEUE_DEPTH + 1);

    tccs_pkg::out_word_t mem [tccs_pkg::QUEUE_DEPTH];

    logic [tccs_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tccs_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 n_in;
    logic                          pop;

    assign res_valid = (count_reg != '0);
    assign res_word  = mem[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;
    assign space_ok  = (count_reg <= CW'(tccs_pkg::QUEUE_DEPTH - 3));
    assign n_in      = push_en ? CW'(push.count) : '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + tccs_pkg::QUEUE_AW'(n_in);
        rd_ptr_next = rd_ptr_reg + tccs_pkg::QUEUE_AW'(pop);
        count_next  = count_reg + n_in - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (push_en && (i < int'(push.count)))
                mem[wr_ptr_reg + tccs_pkg::QUEUE_AW'(i)] <= push.word[i];
        end
    end

endmodule

/* design/text_console_cursor_scroll_core.sv */
// Top level of the text console cursor and scroll core.
// Throughput: one character per cycle while each yields at most one result word and the
// receiver does not stall; else the single result port paces it at one word per cycle,
// up to three per character. Reset clears the cursor, the start row, discarding and the
// result queue, and loads the register defaults (80 columns, 30 rows, font 32 to 126,
// colour 0xFFFF).
module text_console_cursor_scroll_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_stall,
    input  tccs_pkg::in_word_t  char_word,
    output logic                res_valid,
    input  logic                res_stall,
    output tccs_pkg::out_word_t res_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    tccs_pkg::cfg_t  cfg;
    tccs_pkg::push_t push;
    logic            push_en;
    logic            space_ok;

    tccs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tccs_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word),
        .space_ok   (space_ok),
        .push_en    (push_en),
        .push       (push)
    );

    tccs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (push_en),
        .push      (push),
        .space_ok  (space_ok),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule

/* design/tccs_checker.sv */
// Port-level checker of the text console cursor and scroll core, with its bind.
module tccs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_stall,
    input tccs_pkg::out_word_t res_word
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_word))
        else $error("Stalled result word changed or was withdrawn.");

    a_clear_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.kind == tccs_pkg::KIND_CLEARED |->
            res_word.ring_row == 6'd0 && res_word.column == 7'd0 &&
            res_word.top_row == 6'd0 && res_word.last)
        else $error("Cleared word does not show a home cursor as the final word.");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.kind == tccs_pkg::KIND_FONT_ERROR |-> res_word.last)
        else $error("Font error word is not the final word of its character.");

    a_cell_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.kind != tccs_pkg::KIND_CELL |->
            res_word.glyph_index == 8'd0 && res_word.cell_colour == 16'd0)
        else $error("Glyph or colour set on a word that is not a cell write.");

endmodule

bind text_console_cursor_scroll_core tccs_checker u_tccs_checker (.*);

/* tb/sv/testbench.sv */
// Self-checking testbench of the text console cursor and scroll core.
`timescale 1ns / 100ps

module testbench;

    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 48;

    typedef struct {
        bit                  on;
        tccs_pkg::out_word_t w;
    } quote_t;

    typedef struct {
        bit                   is_cfg;
        tccs_pkg::cfg_index_t idx;
        logic [15:0]          data;
        tccs_pkg::in_word_t   w;
        bit                   quoted;
        tccs_pkg::out_word_t  want;
    } plan_row_t;

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                char_valid = 1'b0;
    logic                char_stall;
    tccs_pkg::in_word_t  char_word  = '0;
    logic                res_valid;
    logic                res_stall  = 1'b0;
    tccs_pkg::out_word_t res_word;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_index  = '0;
    logic [15:0]         cfg_data   = '0;

    logic [7:0]  reg_columns = 8'd80;
    logic [6:0]  reg_rows    = 7'd30;
    logic [7:0]  reg_lowest  = 8'd32;
    logic [7:0]  reg_highest = 8'd126;
    logic [15:0] reg_colour  = 16'hFFFF;

    int cur_row   = 0;
    int cur_col   = 0;
    int view_top  = 0;
    bit skipping  = 1'b0;
    int rows_eff  = 1;

    tccs_pkg::out_word_t due_words[$];
    quote_t              quoted_words[$];
    plan_row_t           plan[$];
    int                  failures = 0;
    int                  burst_left = 0;
    bit                  hold_off_req = 1'b0;

    text_console_cursor_scroll_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_word   (res_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("text_console_cursor_scroll_core: mismatch");
        $finish;
    end

    function automatic tccs_pkg::out_word_t result_of(input tccs_pkg::kind_t k, input int ring,
                                                      input int scr, input int col,
                                                      input int glyph, input int colour,
                                                      input int top, input bit last);
        tccs_pkg::out_word_t r;
        r.kind        = k;
        r.ring_row    = 6'(ring);
        r.screen_row  = 6'(scr);
        r.column      = 7'(col);
        r.glyph_index = 8'(glyph);
        r.cell_colour = 16'(colour);
        r.top_row     = 6'(top);
        r.last        = last;
        return r;
    endfunction

    function automatic void note_result(input tccs_pkg::kind_t k, input int ring, input int col,
                                        input int glyph, input int colour);
        int scr;
        scr = (ring >= view_top) ? ring - view_top : ring + rows_eff - view_top;
        due_words.push_back(result_of(k, ring, scr, col, glyph, colour, view_top, 1'b0));
    endfunction

    function automatic bit step_down();
        cur_row = (cur_row + 1 >= rows_eff) ? 0 : cur_row + 1;
        if (cur_row == view_top)
        begin
            view_top = (view_top + 1 >= rows_eff) ? 0 : view_top + 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void advance_console(input tccs_pkg::in_word_t w);
        int                  cols;
        int                  n0;
        bit                  done;
        tccs_pkg::out_word_t tail;
        cols = (reg_columns == 0) ? 1 : ((reg_columns > tccs_pkg::MAX_COLUMNS) ?
               tccs_pkg::MAX_COLUMNS : reg_columns);
        rows_eff = (reg_rows == 0) ? 1 : ((reg_rows > tccs_pkg::MAX_ROWS) ?
                   tccs_pkg::MAX_ROWS : reg_rows);
        if (cur_row >= rows_eff) cur_row = 0;
        if (cur_col >= cols) cur_col = 0;
        if (view_top >= rows_eff) view_top = 0;
        n0 = due_words.size();
        done = 1'b0;
        if (w.opcode == tccs_pkg::OP_CLEAR)
        begin
            cur_row  = 0;
            cur_col  = 0;
            view_top = 0;
            skipping = 1'b0;
            note_result(tccs_pkg::KIND_CLEARED, 0, 0, 0, 0);
        end
        else if (skipping)
        begin
            if (w.end_of_write) skipping = 1'b0;
        end
        else
        begin
            if (w.char_code == tccs_pkg::CODE_BS)
            begin
                if (!(cur_col == 0 && cur_row == view_top))
                begin
                    if (cur_col == 0) cur_row = (cur_row == 0) ? rows_eff - 1 : cur_row - 1;
                    cur_col = (cur_col == 0) ? cols - 1 : cur_col - 1;
                end
            end
            else if (w.char_code == tccs_pkg::CODE_CR)
                cur_col = 0;
            else if (w.char_code == tccs_pkg::CODE_LF)
            begin
                if (step_down()) note_result(tccs_pkg::KIND_SCROLL, cur_row, cur_col, 0, 0);
            end
            else if (w.char_code < reg_lowest || w.char_code > reg_highest)
            begin
                note_result(tccs_pkg::KIND_FONT_ERROR, cur_row, cur_col, 0, 0);
                skipping = !w.end_of_write;
                done = 1'b1;
            end
            else
            begin
                note_result(tccs_pkg::KIND_CELL, cur_row, cur_col, w.char_code - reg_lowest,
                            reg_colour);
                cur_col = (cur_col + 1 >= cols) ? 0 : cur_col + 1;
                if (cur_col == 0 && step_down())
                    note_result(tccs_pkg::KIND_SCROLL, cur_row, cur_col, 0, 0);
            end
            if (!done && w.end_of_write)
                note_result(tccs_pkg::KIND_CURSOR, cur_row, cur_col, 0, 0);
        end
        if (due_words.size() > n0)
        begin
            tail = due_words.pop_back();
            tail.last = 1'b1;
            due_words.push_back(tail);
        end
    endfunction

    function automatic void report_field(input string name, input int unsigned want,
                                         input int unsigned got);
        if (want != got)
        begin
            failures++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        tccs_pkg::out_word_t want;
        quote_t              quote;
        int                  n0;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (due_words.size() == 0)
                begin
                    failures++;
                    $display("%0t: no result expected, actual %h", $time, res_word);
                end
                else
                begin
                    want = due_words.pop_front();
                    report_field("kind", want.kind, res_word.kind);
                    report_field("ring_row", want.ring_row, res_word.ring_row);
                    report_field("screen_row", want.screen_row, res_word.screen_row);
                    report_field("column", want.column, res_word.column);
                    report_field("glyph_index", want.glyph_index, res_word.glyph_index);
                    report_field("cell_colour", want.cell_colour, res_word.cell_colour);
                    report_field("top_row", want.top_row, res_word.top_row);
                    report_field("last", want.last, res_word.last);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tccs_pkg::CFG_COLUMNS: reg_columns = cfg_data[7:0];
                    tccs_pkg::CFG_ROWS:    reg_rows    = cfg_data[6:0];
                    tccs_pkg::CFG_LOWEST:  reg_lowest  = cfg_data[7:0];
                    tccs_pkg::CFG_HIGHEST: reg_highest = cfg_data[7:0];
                    tccs_pkg::CFG_COLOUR:  reg_colour  = cfg_data;
                    default: ;
                endcase
            end
            if (char_valid && !char_stall)
            begin
                quote = quoted_words.pop_front();
                n0 = due_words.size();
                advance_console(char_word);
                if (quote.on && due_words.size() > n0) due_words[n0] = quote.w;
            end
        end
    end

    initial
    begin : receiver
        int mode;
        int len;
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                mode = 3;
                len  = HOLD_CYCLES;
            end
            else
            begin
                mode = $urandom_range(0, 2);
                len  = $urandom_range(1, 30);
            end
            repeat (len)
            begin
                @(posedge clk);
                case (mode)
                    0: res_stall <= 1'b0;
                    1: res_stall <= ($urandom_range(0, 3) == 0);
                    2: res_stall <= 1'($urandom_range(0, 1));
                    default: res_stall <= 1'b1;
                endcase
            end
        end
    end

    task automatic offer(input tccs_pkg::in_word_t w, input bit quoted,
                         input tccs_pkg::out_word_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
        end
        burst_left--;
        quoted_words.push_back('{quoted, want});
        char_valid <= 1'b1;
        char_word  <= w;
        do @(posedge clk); while (char_stall);
    endtask

    task automatic settle();
        char_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (due_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    function automatic plan_row_t char_item(input logic [7:0] code, input logic eow);
        plan_row_t p;
        p.is_cfg = 1'b0;
        p.idx    = tccs_pkg::CFG_COLUMNS;
        p.data   = '0;
        p.w      = '{tccs_pkg::OP_WRITE, code, eow};
        p.quoted = 1'b0;
        p.want   = '0;
        return p;
    endfunction

    function automatic plan_row_t quoted_item(input logic [7:0] code, input logic eow,
                                              input tccs_pkg::out_word_t want);
        plan_row_t p;
        p = char_item(code, eow);
        p.quoted = 1'b1;
        p.want   = want;
        return p;
    endfunction

    function automatic plan_row_t clear_item(input logic [7:0] code, input logic eow);
        plan_row_t p;
        p = quoted_item(code, eow, result_of(tccs_pkg::KIND_CLEARED, 0, 0, 0, 0, 0, 0, 1'b1));
        p.w.opcode = tccs_pkg::OP_CLEAR;
        return p;
    endfunction

    function automatic plan_row_t reg_item(input tccs_pkg::cfg_index_t idx,
                                           input logic [15:0] data);
        plan_row_t p;
        p = char_item(8'd0, 1'b0);
        p.is_cfg = 1'b1;
        p.idx    = idx;
        p.data   = data;
        return p;
    endfunction

    function automatic tccs_pkg::in_word_t pick_char();
        tccs_pkg::in_word_t w;
        int                 r;
        r = $urandom_range(0, 99);
        w.opcode       = tccs_pkg::OP_WRITE;
        w.end_of_write = 1'b0;
        if (r < 3)
        begin
            w.opcode       = tccs_pkg::OP_CLEAR;
            w.char_code    = 8'($urandom);
            w.end_of_write = 1'($urandom);
        end
        else if (r < 60)
            w.char_code = 8'($urandom_range(reg_highest, reg_lowest));
        else if (r < 80)
        begin
            case ($urandom_range(0, 2))
                0: w.char_code = tccs_pkg::CODE_BS;
                1: w.char_code = tccs_pkg::CODE_CR;
                default: w.char_code = tccs_pkg::CODE_LF;
            endcase
        end
        else
            w.char_code = 8'($urandom);
        return w;
    endfunction

    task automatic configure(input int phase);
        logic [7:0]  cols;
        logic [6:0]  rows;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [15:0] colour;
        lo     = 8'($urandom_range(0, 64));
        hi     = lo + 8'($urandom_range(0, 100));
        colour = 16'($urandom);
        cols   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(2, 12));
        rows   = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(2, 6));
        case (phase)
            0:
            begin
                cols = 8'd128; rows = 7'd64; lo = 8'd0; hi = 8'd255; colour = 16'h0000;
            end
            1:
            begin
                cols = 8'd1; rows = 7'd1; lo = 8'd32; hi = 8'd126; colour = 16'hFFFF;
            end
            2:
            begin
                cols = 8'd255; rows = 7'd127;
            end
            3:
            begin
                cols = 8'd0; rows = 7'd0;
            end
            4:
            begin
                lo = 8'd200; hi = 8'd10;
            end
            default: ;
        endcase
        write_reg(tccs_pkg::CFG_COLUMNS, {8'd0, cols});
        write_reg(tccs_pkg::CFG_ROWS, {9'd0, rows});
        write_reg(tccs_pkg::CFG_LOWEST, {8'd0, lo});
        write_reg(tccs_pkg::CFG_HIGHEST, {8'd0, hi});
        write_reg(tccs_pkg::CFG_COLOUR, colour);
        if (phase == 0)
            for (int i = tccs_pkg::CFG_COLOUR + 1; i < 8; i++) write_reg(3'(i), 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int items);
        tccs_pkg::in_word_t w;
        int                 sent;
        int                 len;
        bit                 broken;
        sent = 0;
        while (sent < items)
        begin
            len    = $urandom_range(1, 10);
            broken = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++)
            begin
                w = pick_char();
                if (w.opcode != tccs_pkg::OP_CLEAR)
                    w.end_of_write = broken ? 1'($urandom_range(0, 1)) : (i == len - 1);
                offer(w, 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        bit in_cfg;
        in_cfg = 1'b0;

        plan.push_back(clear_item(8'hFF, 1'b0));
        plan.push_back(quoted_item(8'd65, 1'b0,
            result_of(tccs_pkg::KIND_CELL, 0, 0, 0, 33, 16'hFFFF, 0, 1'b1)));
        plan.push_back(quoted_item(8'd126, 1'b1,
            result_of(tccs_pkg::KIND_CELL, 0, 0, 1, 94, 16'hFFFF, 0, 1'b0)));
        plan.push_back(quoted_item(8'd32, 1'b0,
            result_of(tccs_pkg::KIND_CELL, 0, 0, 2, 0, 16'hFFFF, 0, 1'b1)));
        plan.push_back(char_item(tccs_pkg::CODE_BS, 1'b0));
        plan.push_back(quoted_item(tccs_pkg::CODE_CR, 1'b1,
            result_of(tccs_pkg::KIND_CURSOR, 0, 0, 0, 0, 0, 0, 1'b1)));
        plan.push_back(quoted_item(tccs_pkg::CODE_BS, 1'b1,
            result_of(tccs_pkg::KIND_CURSOR, 0, 0, 0, 0, 0, 0, 1'b1)));
        plan.push_back(char_item(tccs_pkg::CODE_LF, 1'b0));
        plan.push_back(char_item(tccs_pkg::CODE_BS, 1'b0));
        plan.push_back(char_item(8'd120, 1'b1));
        plan.push_back(quoted_item(8'd31, 1'b0,
            result_of(tccs_pkg::KIND_FONT_ERROR, 1, 1, 0, 0, 0, 0, 1'b1)));
        plan.push_back(char_item(8'd66, 1'b0));
        plan.push_back(char_item(tccs_pkg::CODE_LF, 1'b1));
        plan.push_back(quoted_item(8'd127, 1'b1,
            result_of(tccs_pkg::KIND_FONT_ERROR, 1, 1, 0, 0, 0, 0, 1'b1)));
        plan.push_back(quoted_item(8'd255, 1'b0,
            result_of(tccs_pkg::KIND_FONT_ERROR, 1, 1, 0, 0, 0, 0, 1'b1)));
        plan.push_back(clear_item(8'h00, 1'b1));
        plan.push_back(reg_item(tccs_pkg::CFG_COLUMNS, 16'd0));
        plan.push_back(reg_item(tccs_pkg::CFG_ROWS, 16'd0));
        plan.push_back(char_item(8'd67, 1'b1));
        plan.push_back(char_item(tccs_pkg::CODE_LF, 1'b1));
        plan.push_back(reg_item(tccs_pkg::CFG_COLUMNS, 16'd200));
        plan.push_back(reg_item(tccs_pkg::CFG_ROWS, 16'd3));
        plan.push_back(reg_item(tccs_pkg::CFG_LOWEST, 16'd0));
        plan.push_back(reg_item(tccs_pkg::CFG_HIGHEST, 16'd255));
        plan.push_back(reg_item(tccs_pkg::CFG_COLOUR, 16'h0000));
        plan.push_back(char_item(tccs_pkg::CODE_CR, 1'b0));
        plan.push_back(char_item(tccs_pkg::CODE_LF, 1'b0));
        plan.push_back(char_item(tccs_pkg::CODE_LF, 1'b0));
        plan.push_back(char_item(tccs_pkg::CODE_LF, 1'b1));
        plan.push_back(char_item(tccs_pkg::CODE_BS, 1'b1));
        plan.push_back(reg_item(tccs_pkg::CFG_ROWS, 16'd1));
        plan.push_back(reg_item(tccs_pkg::CFG_COLUMNS, 16'd64));
        plan.push_back(char_item(8'd68, 1'b1));
        plan.push_back(reg_item(tccs_pkg::CFG_LOWEST, 16'd100));
        plan.push_back(reg_item(tccs_pkg::CFG_HIGHEST, 16'd50));
        plan.push_back(char_item(8'd101, 1'b1));
        plan.push_back(char_item(tccs_pkg::CODE_BS, 1'b1));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < plan.size(); i++)
        begin
            if (plan[i].is_cfg)
            begin
                if (!in_cfg)
                begin
                    settle();
                    in_cfg = 1'b1;
                end
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                if (in_cfg)
                begin
                    cfg_valid <= 1'b0;
                    in_cfg = 1'b0;
                end
                offer(plan[i].w, plan[i].quoted, plan[i].want);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            configure(phase);
            // The receiver holds off for a long stretch while characters keep coming.
            if (phase == 3) hold_off_req = 1'b1;
            if (phase == 5)
            begin
                run_phase(PHASE_ITEMS / 2);
                settle();
                run_phase(PHASE_ITEMS / 2);
            end
            else
                run_phase(PHASE_ITEMS);
        end

        settle();
        if (failures == 0)
            $display("text_console_cursor_scroll_core: match");
        else
            $display("text_console_cursor_scroll_core: mismatch");
        $finish;
    end

endmodule
